FILE: hw/rtl/tad_pkg.sv
// shared types and constants of the thermistor adc to temperature converter
`default_nettype none
package tad_pkg;

   // configuration register indexes
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS = 20;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ADC_FULL_SCALE = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_VREF_MILLIVOLTS = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PULLUP_OHMS = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_R25_OHMS = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BETA_KELVIN = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_REFERENCE_CENTIKELVIN = 3'd5;

   // register widths
   localparam int FS_BITS = 16;
   localparam int VREF_BITS = 13;
   localparam int OHM_BITS = 20;
   localparam int BETA_BITS = 14;
   localparam int T0_BITS = 16;

   // result fields
   localparam int TEMP_BITS = 15;
   localparam int STATUS_BITS = 3;
   localparam logic [STATUS_BITS-1:0] ST_NORMAL = 3'd0;
   localparam logic [STATUS_BITS-1:0] ST_OPEN = 3'd1;
   localparam logic [STATUS_BITS-1:0] ST_SHORTED = 3'd2;
   localparam logic [STATUS_BITS-1:0] ST_CLAMP_LOW = 3'd3;
   localparam logic [STATUS_BITS-1:0] ST_CLAMP_HIGH = 3'd4;

   localparam logic signed [TEMP_BITS-1:0] TEMP_MAX_CENTI = 15'sd12500;
   localparam logic signed [TEMP_BITS-1:0] TEMP_MIN_CENTI = -15'sd4000;
   localparam logic signed [TEMP_BITS-1:0] OPEN_CENTI = -15'sd12700;

   // conversion constants
   localparam int OPEN_LIMIT = 10;
   localparam int NEAR_SUPPLY_MV = 3290;
   localparam int HIGH_R_FACTOR = 100;
   localparam int CENTI_SCALE = 100;
   localparam int ZERO_C_CENTIKELVIN = 27315;
   localparam int HOT_LIMIT_CENTIKELVIN = 39815;

   // resistance and log datapath
   localparam int R_BITS = 33;
   localparam int NORM_BITS = 64;
   localparam int MSB_BITS = 6;
   localparam int MANT_BITS = 31;
   localparam int LN2_BITS = 30;
   localparam logic [LN2_BITS-1:0] LN2_Q30 = 30'd744261118;

   // early verdict carried down the pipe
   typedef struct packed {
      logic                   forced;
      logic [STATUS_BITS-1:0] code;
   } verdict_type;

   localparam int VERDICT_BITS = $bits(verdict_type);

endpackage
`default_nettype wire

FILE: hw/rtl/tad_div_cell.sv
// one restoring division cell: settles one quotient bit per cycle
`default_nettype none
module tad_div_cell
   import tad_pkg::*;
#(
   parameter int NUM_BITS = 8,
   parameter int DIV_BITS = 8,
   parameter int PAY_BITS = 1
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         up_valid,
   input  logic [DIV_BITS+NUM_BITS-1:0] up_acc,
   input  logic [DIV_BITS-1:0]          up_div,
   input  logic [PAY_BITS-1:0]          up_pay,
   output logic                         dn_valid,
   output logic [DIV_BITS+NUM_BITS-1:0] dn_acc,
   output logic [DIV_BITS-1:0]          dn_div,
   output logic [PAY_BITS-1:0]          dn_pay
);

   logic [DIV_BITS:0]          top;
   logic [DIV_BITS:0]          diff;
   logic                       qbit;
   logic [DIV_BITS-1:0]        rem;
   logic [DIV_BITS+NUM_BITS-1:0] acc_in;
   logic [DIV_BITS+NUM_BITS-1:0] acc_ff;
   logic [DIV_BITS-1:0]        div_ff;
   logic [PAY_BITS-1:0]        pay_ff;
   logic                       valid_ff;

   // shift in the next dividend bit and try a subtract
   always_comb begin
      top = up_acc[DIV_BITS+NUM_BITS-1 -: DIV_BITS+1];
      diff = top - {1'b0, up_div};
      qbit = (top >= {1'b0, up_div});
      rem = qbit ? diff[DIV_BITS-1:0] : top[DIV_BITS-1:0];
      acc_in = {rem, up_acc[NUM_BITS-2:0], qbit};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= up_valid;
      end
      acc_ff <= acc_in;
      div_ff <= up_div;
      pay_ff <= up_pay;
   end

   assign dn_valid = valid_ff;
   assign dn_acc = acc_ff;
   assign dn_div = div_ff;
   assign dn_pay = pay_ff;

endmodule
`default_nettype wire

FILE: hw/rtl/tad_divider.sv
// pipelined restoring divider: a row of division cells, one per quotient bit
`default_nettype none
module tad_divider
   import tad_pkg::*;
#(
   parameter int NUM_BITS = 8,
   parameter int DIV_BITS = 8,
   parameter int PAY_BITS = 1
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                up_valid,
   input  logic [NUM_BITS-1:0] up_num,
   input  logic [DIV_BITS-1:0] up_div,
   input  logic [PAY_BITS-1:0] up_pay,
   output logic                dn_valid,
   output logic [NUM_BITS-1:0] dn_quot,
   output logic [PAY_BITS-1:0] dn_pay
);

   logic                         valid_w [NUM_BITS+1];
   logic [DIV_BITS+NUM_BITS-1:0] acc_w [NUM_BITS+1];
   logic [DIV_BITS-1:0]          div_w [NUM_BITS];
   logic [PAY_BITS-1:0]          pay_w [NUM_BITS+1];

   assign valid_w[0] = up_valid;
   assign acc_w[0] = {{DIV_BITS{1'b0}}, up_num};
   assign div_w[0] = up_div;
   assign pay_w[0] = up_pay;

   // chain of cells, most significant quotient bit first
   for (genvar i = 0; i < NUM_BITS; i++) begin : g_cell
      if (i < NUM_BITS - 1) begin : g_mid
         tad_div_cell #(
            .NUM_BITS(NUM_BITS),
            .DIV_BITS(DIV_BITS),
            .PAY_BITS(PAY_BITS)
         ) u_cell (
            .clock(clock),
            .reset(reset),
            .up_valid(valid_w[i]),
            .up_acc(acc_w[i]),
            .up_div(div_w[i]),
            .up_pay(pay_w[i]),
            .dn_valid(valid_w[i+1]),
            .dn_acc(acc_w[i+1]),
            .dn_div(div_w[i+1]),
            .dn_pay(pay_w[i+1])
         );
      end else begin : g_last
         tad_div_cell #(
            .NUM_BITS(NUM_BITS),
            .DIV_BITS(DIV_BITS),
            .PAY_BITS(PAY_BITS)
         ) u_cell (
            .clock(clock),
            .reset(reset),
            .up_valid(valid_w[i]),
            .up_acc(acc_w[i]),
            .up_div(div_w[i]),
            .up_pay(pay_w[i]),
            .dn_valid(valid_w[i+1]),
            .dn_acc(acc_w[i+1]),
            .dn_div(),
            .dn_pay(pay_w[i+1])
         );
      end
   end

   assign dn_valid = valid_w[NUM_BITS];
   assign dn_quot = acc_w[NUM_BITS][NUM_BITS-1:0];
   assign dn_pay = pay_w[NUM_BITS];

endmodule
`default_nettype wire

FILE: hw/rtl/tad_log.sv
// two-lane pipelined natural log: normalizer cells, squaring cells, ln2 scaling
`default_nettype none
module tad_log
   import tad_pkg::*;
#(
   parameter int FRAC_BITS = 16,
   parameter int PAY_BITS = 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          up_valid,
   input  logic [R_BITS-1:0]             up_x_a,
   input  logic [R_BITS-1:0]             up_x_b,
   input  logic [PAY_BITS-1:0]           up_pay,
   output logic                          dn_valid,
   output logic [FRAC_BITS+MSB_BITS-1:0] dn_ln_a,
   output logic [FRAC_BITS+MSB_BITS-1:0] dn_ln_b,
   output logic [PAY_BITS-1:0]           dn_pay
);

   localparam int LW = FRAC_BITS + MSB_BITS;
   localparam int LANES = 2;
   localparam int NS = MSB_BITS;

   logic [NORM_BITS-1:0] x_init [LANES];

   logic [NORM_BITS-1:0] nw_in [LANES][NS];
   logic [NORM_BITS-1:0] nw_ff [LANES][NS];
   logic [MSB_BITS-1:0]  lz_in [LANES][NS];
   logic [MSB_BITS-1:0]  lz_ff [LANES][NS];
   logic                 nv_ff [NS];
   logic [PAY_BITS-1:0]  np_ff [NS];

   logic [MANT_BITS-1:0] m_in [LANES][FRAC_BITS];
   logic [MANT_BITS-1:0] m_ff [LANES][FRAC_BITS];
   logic [LW-1:0]        lg_in [LANES][FRAC_BITS];
   logic [LW-1:0]        lg_ff [LANES][FRAC_BITS];
   logic                 sv_ff [FRAC_BITS];
   logic [PAY_BITS-1:0]  sp_ff [FRAC_BITS];

   logic [LW-1:0]        ln_in [LANES];
   logic [LW-1:0]        ln_ff [LANES];
   logic                 valid_ff;
   logic [PAY_BITS-1:0]  pay_ff;

   // zero reads as one
   always_comb begin
      x_init[0] = (up_x_a == '0) ? NORM_BITS'(1) : NORM_BITS'(up_x_a);
      x_init[1] = (up_x_b == '0) ? NORM_BITS'(1) : NORM_BITS'(up_x_b);
   end

   // normalizer: each cell closes a power-of-two share of the leading zeros
   for (genvar k = 0; k < NS; k++) begin : g_norm
      localparam int SH = NORM_BITS >> (k + 1);
      for (genvar l = 0; l < LANES; l++) begin : g_lane
         logic [NORM_BITS-1:0] w_src;
         logic [MSB_BITS-1:0]  lz_src;
         if (k == 0) begin : g_first
            assign w_src = x_init[l];
            assign lz_src = '0;
         end else begin : g_next
            assign w_src = nw_ff[l][k-1];
            assign lz_src = lz_ff[l][k-1];
         end
         always_comb begin
            if (w_src[NORM_BITS-1 -: SH] == '0) begin
               nw_in[l][k] = w_src << SH;
               lz_in[l][k] = lz_src | MSB_BITS'(SH);
            end else begin
               nw_in[l][k] = w_src;
               lz_in[l][k] = lz_src;
            end
         end
         always_ff @(posedge clock) begin
            nw_ff[l][k] <= nw_in[l][k];
            lz_ff[l][k] <= lz_in[l][k];
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            nv_ff[k] <= 1'b0;
         end else if (k == 0) begin
            nv_ff[k] <= up_valid;
         end else begin
            nv_ff[k] <= nv_ff[(k == 0) ? 0 : k-1];
         end
         np_ff[k] <= (k == 0) ? up_pay : np_ff[(k == 0) ? 0 : k-1];
      end
   end

   // squaring cells: one fraction bit of log2 per cell
   for (genvar j = 0; j < FRAC_BITS; j++) begin : g_sq
      for (genvar l = 0; l < LANES; l++) begin : g_lane
         logic [MANT_BITS-1:0]   m_src;
         logic [LW-1:0]          lg_src;
         logic [2*MANT_BITS-1:0] prod;
         logic [MANT_BITS:0]     sq;
         if (j == 0) begin : g_first
            assign m_src = nw_ff[l][NS-1][NORM_BITS-1 -: MANT_BITS];
            assign lg_src = LW'(MSB_BITS'(NORM_BITS - 1) - lz_ff[l][NS-1]);
         end else begin : g_next
            assign m_src = m_ff[l][j-1];
            assign lg_src = lg_ff[l][j-1];
         end
         always_comb begin
            prod = m_src * m_src;
            sq = prod[2*MANT_BITS-1:MANT_BITS-1];
            if (sq[MANT_BITS]) begin
               m_in[l][j] = sq[MANT_BITS:1];
               lg_in[l][j] = {lg_src[LW-2:0], 1'b1};
            end else begin
               m_in[l][j] = sq[MANT_BITS-1:0];
               lg_in[l][j] = {lg_src[LW-2:0], 1'b0};
            end
         end
         always_ff @(posedge clock) begin
            m_ff[l][j] <= m_in[l][j];
            lg_ff[l][j] <= lg_in[l][j];
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            sv_ff[j] <= 1'b0;
         end else if (j == 0) begin
            sv_ff[j] <= nv_ff[NS-1];
         end else begin
            sv_ff[j] <= sv_ff[(j == 0) ? 0 : j-1];
         end
         sp_ff[j] <= (j == 0) ? np_ff[NS-1] : sp_ff[(j == 0) ? 0 : j-1];
      end
   end

   // scale log2 by ln2, rounded half up
   for (genvar l = 0; l < LANES; l++) begin : g_scale
      logic [LW+LN2_BITS:0] scaled;
      always_comb begin
         scaled = (LW+LN2_BITS+1)'(lg_ff[l][FRAC_BITS-1]) * (LW+LN2_BITS+1)'(LN2_Q30)
                + ((LW+LN2_BITS+1)'(1) << (LN2_BITS - 1));
         ln_in[l] = scaled[LN2_BITS +: LW];
      end
      always_ff @(posedge clock) begin
         ln_ff[l] <= ln_in[l];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= sv_ff[FRAC_BITS-1];
      end
      pay_ff <= sp_ff[FRAC_BITS-1];
   end

   assign dn_valid = valid_ff;
   assign dn_ln_a = ln_ff[0];
   assign dn_ln_b = ln_ff[1];
   assign dn_pay = pay_ff;

endmodule
`default_nettype wire

FILE: hw/rtl/thermistor_adc_to_temperature.sv
// thermistor divider adc sample to temperature, top level
//
// Takes one sample per clock (busy stays low) and returns one result per
// sample, in order, with a one-cycle rsp_strobe; the receiver cannot stall and
// must take each result in the cycle it appears. The path runs through the
// three restoring dividers (one quotient bit per cell: voltage, resistance,
// temperature) and the log pipeline (six normalizer cells, one squaring cell
// per fraction bit, one scaling stage). Configuration writes take effect at
// once and belong to quiet periods with no sample in flight.
`default_nettype none
module thermistor_adc_to_temperature
   import tad_pkg::*;
#(
   parameter int ADC_BITS = 12,
   parameter int LOG_FRACTION_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [ADC_BITS-1:0]           req_adc_sample,
   output logic                          rsp_strobe,
   output logic signed [TEMP_BITS-1:0]   rsp_temperature_centi,
   output logic [STATUS_BITS-1:0]        rsp_status,
   input  logic                          csr_write,
   input  logic [CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [CSR_DATA_BITS-1:0]      csr_data
);

   localparam int F = LOG_FRACTION_BITS;
   localparam int LW = F + MSB_BITS;
   localparam int PV_BITS = ADC_BITS + VREF_BITS;
   localparam int NEAR_PAY_BITS = VERDICT_BITS + 1;
   localparam int NUM0_BITS = 21 + F;
   localparam int BT_BITS = BETA_BITS + T0_BITS;
   localparam int LT_BITS = LW + T0_BITS + 2;
   localparam int DSW = LT_BITS + 1;
   localparam int DENW = DSW - 1;
   localparam int NUMK_BITS = BT_BITS + 7;
   localparam int NUMW = NUMK_BITS + F + 1;

   // configuration registers
   logic [FS_BITS-1:0]   full_scale_ff;
   logic [VREF_BITS-1:0] vref_ff;
   logic [OHM_BITS-1:0]  pullup_ff;
   logic [OHM_BITS-1:0]  r25_ff;
   logic [BETA_BITS-1:0] beta_ff;
   logic [T0_BITS-1:0]   t0_ff;

   logic [FS_BITS-1:0]   fs_eff;
   logic [OHM_BITS-1:0]  r25_eff;
   logic [BETA_BITS-1:0] beta_eff;
   logic [T0_BITS-1:0]   t0_eff;

   always_ff @(posedge clock) begin
      if (reset) begin
         full_scale_ff <= FS_BITS'((1 << ADC_BITS) - 1);
         vref_ff <= VREF_BITS'(3300);
         pullup_ff <= OHM_BITS'(10000);
         r25_ff <= OHM_BITS'(10000);
         beta_ff <= BETA_BITS'(3950);
         t0_ff <= T0_BITS'(29815);
      end else if (csr_write) begin
         case (csr_index)
            CSR_ADC_FULL_SCALE: full_scale_ff <= csr_data[FS_BITS-1:0];
            CSR_VREF_MILLIVOLTS: vref_ff <= csr_data[VREF_BITS-1:0];
            CSR_PULLUP_OHMS: pullup_ff <= csr_data[OHM_BITS-1:0];
            CSR_R25_OHMS: r25_ff <= csr_data[OHM_BITS-1:0];
            CSR_BETA_KELVIN: beta_ff <= csr_data[BETA_BITS-1:0];
            CSR_REFERENCE_CENTIKELVIN: t0_ff <= csr_data[T0_BITS-1:0];
            default: ;
         endcase
      end
   end

   // zero full scale, r25, beta and t0 values read as one
   assign fs_eff = (full_scale_ff == '0) ? FS_BITS'(1) : full_scale_ff;
   assign r25_eff = (r25_ff == '0) ? OHM_BITS'(1) : r25_ff;
   assign beta_eff = (beta_ff == '0) ? BETA_BITS'(1) : beta_ff;
   assign t0_eff = (t0_ff == '0) ? T0_BITS'(1) : t0_ff;

   assign busy = 1'b0;

   // stage a: sample transfer, scale by vref, open sensor test
   logic               a_valid_ff;
   logic [PV_BITS-1:0] a_prod_ff;
   verdict_type        a_verdict_in;
   verdict_type        a_verdict_ff;

   always_comb begin
      a_verdict_in.forced = (req_adc_sample < ADC_BITS'(OPEN_LIMIT));
      a_verdict_in.code = ST_OPEN;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= start && !busy;
      end
      a_prod_ff <= PV_BITS'(req_adc_sample) * PV_BITS'(vref_ff);
      a_verdict_ff <= a_verdict_in;
   end

   // voltage in millivolts
   logic                    d1_valid;
   logic [PV_BITS-1:0]      d1_quot;
   logic [VERDICT_BITS-1:0] d1_pay;

   tad_divider #(
      .NUM_BITS(PV_BITS),
      .DIV_BITS(FS_BITS),
      .PAY_BITS(VERDICT_BITS)
   ) u_div_volt (
      .clock(clock),
      .reset(reset),
      .up_valid(a_valid_ff),
      .up_num(a_prod_ff),
      .up_div(fs_eff),
      .up_pay(a_verdict_ff),
      .dn_valid(d1_valid),
      .dn_quot(d1_quot),
      .dn_pay(d1_pay)
   );

   // stage b: near supply test, divider numerator and headroom
   logic                 b_near;
   logic [VREF_BITS-1:0] b_v;
   logic                 b_valid_ff;
   logic [R_BITS-1:0]    b_prod_ff;
   logic [VREF_BITS-1:0] b_den_ff;
   logic [NEAR_PAY_BITS-1:0] b_pay_ff;

   always_comb begin
      b_near = (d1_quot >= PV_BITS'(NEAR_SUPPLY_MV)) || (d1_quot >= PV_BITS'(vref_ff));
      b_v = d1_quot[VREF_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else begin
         b_valid_ff <= d1_valid;
      end
      b_prod_ff <= R_BITS'(b_v) * R_BITS'(pullup_ff);
      b_den_ff <= b_near ? VREF_BITS'(1) : (vref_ff - b_v);
      b_pay_ff <= {b_near, d1_pay};
   end

   // thermistor resistance in ohms
   logic                     d2_valid;
   logic [R_BITS-1:0]        d2_quot;
   logic [NEAR_PAY_BITS-1:0] d2_pay;

   tad_divider #(
      .NUM_BITS(R_BITS),
      .DIV_BITS(VREF_BITS),
      .PAY_BITS(NEAR_PAY_BITS)
   ) u_div_ohm (
      .clock(clock),
      .reset(reset),
      .up_valid(b_valid_ff),
      .up_num(b_prod_ff),
      .up_div(b_den_ff),
      .up_pay(b_pay_ff),
      .dn_valid(d2_valid),
      .dn_quot(d2_quot),
      .dn_pay(d2_pay)
   );

   // stage c: pick resistance, shorted test
   logic [R_BITS-1:0] c_r;
   verdict_type       c_verdict_in;
   logic              c_valid_ff;
   logic [R_BITS-1:0] c_r_ff;
   verdict_type       c_verdict_ff;

   always_comb begin
      c_r = d2_pay[VERDICT_BITS] ? (R_BITS'(pullup_ff) * R_BITS'(HIGH_R_FACTOR)) : d2_quot;
      c_verdict_in = verdict_type'(d2_pay[VERDICT_BITS-1:0]);
      if (!c_verdict_in.forced && (c_r == '0)) begin
         c_verdict_in.forced = 1'b1;
         c_verdict_in.code = ST_SHORTED;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else begin
         c_valid_ff <= d2_valid;
      end
      c_r_ff <= c_r;
      c_verdict_ff <= c_verdict_in;
   end

   // ln(r) and ln(r25)
   logic                    lg_valid;
   logic [LW-1:0]           lg_ln_r;
   logic [LW-1:0]           lg_ln_r25;
   logic [VERDICT_BITS-1:0] lg_pay;

   tad_log #(
      .FRAC_BITS(F),
      .PAY_BITS(VERDICT_BITS)
   ) u_log (
      .clock(clock),
      .reset(reset),
      .up_valid(c_valid_ff),
      .up_x_a(c_r_ff),
      .up_x_b(R_BITS'(r25_eff)),
      .up_pay(c_verdict_ff),
      .dn_valid(lg_valid),
      .dn_ln_a(lg_ln_r),
      .dn_ln_b(lg_ln_r25),
      .dn_pay(lg_pay)
   );

   // stage d: log ratio times t0, beta terms
   logic signed [LW:0]          d_lnr;
   logic signed [T0_BITS:0]     d_t0s;
   logic                        d_valid_ff;
   logic signed [LT_BITS-1:0]   d_lt_ff;
   logic [NUM0_BITS-1:0]        d_num0_ff;
   logic [BT_BITS-1:0]          d_bt_ff;
   logic [VERDICT_BITS-1:0]     d_pay_ff;

   always_comb begin
      d_lnr = signed'({1'b0, lg_ln_r}) - signed'({1'b0, lg_ln_r25});
      d_t0s = signed'({1'b0, t0_eff});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_valid_ff <= 1'b0;
      end else begin
         d_valid_ff <= lg_valid;
      end
      d_lt_ff <= LT_BITS'(d_lnr * d_t0s);
      d_num0_ff <= (NUM0_BITS'(beta_eff) * NUM0_BITS'(CENTI_SCALE)) << F;
      d_bt_ff <= BT_BITS'(beta_eff) * BT_BITS'(t0_eff);
      d_pay_ff <= lg_pay;
   end

   // stage e: denominator and scaled numerator
   logic signed [DSW-1:0]   e_num0s;
   logic signed [DSW-1:0]   e_lts;
   logic                    e_valid_ff;
   logic signed [DSW-1:0]   e_den_ff;
   logic [NUMK_BITS-1:0]    e_numk_ff;
   logic [VERDICT_BITS-1:0] e_pay_ff;

   always_comb begin
      e_num0s = signed'(DSW'(d_num0_ff));
      e_lts = DSW'(d_lt_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff <= 1'b0;
      end else begin
         e_valid_ff <= d_valid_ff;
      end
      e_den_ff <= e_num0s + e_lts;
      e_numk_ff <= NUMK_BITS'(d_bt_ff) * NUMK_BITS'(CENTI_SCALE);
      e_pay_ff <= d_pay_ff;
   end

   // stage f: sign of denominator, rounded dividend
   verdict_type        f_verdict_in;
   logic               f_pos;
   logic               f_valid_ff;
   logic [NUMW-1:0]    f_dvd_ff;
   logic [DENW-1:0]    f_den_ff;
   verdict_type        f_verdict_ff;

   always_comb begin
      f_verdict_in = verdict_type'(e_pay_ff);
      f_pos = !e_den_ff[DSW-1] && (e_den_ff != '0);
      if (!f_verdict_in.forced && (e_den_ff == '0)) begin
         f_verdict_in.forced = 1'b1;
         f_verdict_in.code = ST_CLAMP_HIGH;
      end else if (!f_verdict_in.forced && e_den_ff[DSW-1]) begin
         f_verdict_in.forced = 1'b1;
         f_verdict_in.code = ST_CLAMP_LOW;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_valid_ff <= 1'b0;
      end else begin
         f_valid_ff <= e_valid_ff;
      end
      f_dvd_ff <= NUMW'({e_numk_ff, {F{1'b0}}}) + NUMW'(e_den_ff[DENW-1:1]);
      f_den_ff <= f_pos ? e_den_ff[DENW-1:0] : DENW'(1);
      f_verdict_ff <= f_verdict_in;
   end

   // temperature in centikelvin
   logic                    d3_valid;
   logic [NUMW-1:0]         d3_quot;
   logic [VERDICT_BITS-1:0] d3_pay;

   tad_divider #(
      .NUM_BITS(NUMW),
      .DIV_BITS(DENW),
      .PAY_BITS(VERDICT_BITS)
   ) u_div_temp (
      .clock(clock),
      .reset(reset),
      .up_valid(f_valid_ff),
      .up_num(f_dvd_ff),
      .up_div(f_den_ff),
      .up_pay(f_verdict_ff),
      .dn_valid(d3_valid),
      .dn_quot(d3_quot),
      .dn_pay(d3_pay)
   );

   // stage g: celsius, clamps and result register
   verdict_type                 g_verdict;
   logic signed [T0_BITS:0]     g_celsius;
   logic signed [TEMP_BITS-1:0] g_temp_in;
   logic [STATUS_BITS-1:0]      g_status_in;
   logic                        g_strobe_ff;
   logic signed [TEMP_BITS-1:0] g_temp_ff;
   logic [STATUS_BITS-1:0]      g_status_ff;

   always_comb begin
      g_verdict = verdict_type'(d3_pay);
      g_celsius = signed'({1'b0, d3_quot[T0_BITS-1:0]})
                - signed'((T0_BITS+1)'(ZERO_C_CENTIKELVIN));
      g_temp_in = TEMP_MAX_CENTI;
      g_status_in = ST_CLAMP_HIGH;
      if (g_verdict.forced) begin
         g_status_in = g_verdict.code;
         case (g_verdict.code)
            ST_OPEN: g_temp_in = OPEN_CENTI;
            ST_CLAMP_LOW: g_temp_in = TEMP_MIN_CENTI;
            default: g_temp_in = TEMP_MAX_CENTI;
         endcase
      end else if (d3_quot > NUMW'(HOT_LIMIT_CENTIKELVIN)) begin
         g_temp_in = TEMP_MAX_CENTI;
         g_status_in = ST_CLAMP_HIGH;
      end else if (g_celsius < (T0_BITS+1)'(TEMP_MIN_CENTI)) begin
         g_temp_in = TEMP_MIN_CENTI;
         g_status_in = ST_CLAMP_LOW;
      end else begin
         g_temp_in = g_celsius[TEMP_BITS-1:0];
         g_status_in = ST_NORMAL;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         g_strobe_ff <= 1'b0;
      end else begin
         g_strobe_ff <= d3_valid;
      end
      g_temp_ff <= g_temp_in;
      g_status_ff <= g_status_in;
   end

   assign rsp_strobe = g_strobe_ff;
   assign rsp_temperature_centi = g_temp_ff;
   assign rsp_status = g_status_ff;

endmodule
`default_nettype wire

FILE: tb/sv/tb_thermistor_adc_to_temperature.sv
// self-checking testbench of the thermistor adc to temperature converter
`timescale 1ns / 1ps
`default_nettype none
module tb_thermistor_adc_to_temperature;
   import tad_pkg::*;

   localparam int ADC_W = 12;
   localparam int FRAC = 16;
   localparam int LATENCY = ADC_W + 2 * FRAC + 98;
   localparam int RANDOM_ITEMS = 550;
   localparam logic [63:0] LN2_WIDE = 64'd744261118;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNUSED_INDEX = 3'd6;

   typedef struct packed {
      logic signed [TEMP_BITS-1:0] temp;
      logic [STATUS_BITS-1:0]      code;
   } reading_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [ADC_W-1:0] req_adc_sample = '0;
   logic rsp_strobe;
   logic signed [TEMP_BITS-1:0] rsp_temperature_centi;
   logic [STATUS_BITS-1:0] rsp_status;
   logic csr_write = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0] csr_data = '0;

   // shadow copy of the configuration
   logic [FS_BITS-1:0]   cfg_fs;
   logic [VREF_BITS-1:0] cfg_vref;
   logic [OHM_BITS-1:0]  cfg_pullup;
   logic [OHM_BITS-1:0]  cfg_r25;
   logic [BETA_BITS-1:0] cfg_beta;
   logic [T0_BITS-1:0]   cfg_t0;

   logic [ADC_W-1:0] sample_queue[$];
   reading_type expected_readings[$];
   int mismatches = 0;
   bit hold_sender = 1'b0;

   thermistor_adc_to_temperature #(.ADC_BITS(ADC_W), .LOG_FRACTION_BITS(FRAC)) dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_adc_sample(req_adc_sample), .rsp_strobe(rsp_strobe),
      .rsp_temperature_centi(rsp_temperature_centi), .rsp_status(rsp_status),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   task automatic report(input string what);
      $display("error at %0t: %s", $realtime, what);
      mismatches++;
   endtask

   // natural log in fixed point with FRAC fraction bits
   function automatic logic [63:0] ln_fixed(input logic [63:0] x);
      int msb;
      logic [63:0] m, lg;
      if (x == 0) x = 1;
      msb = 0;
      while (msb < 63 && (x >> (msb + 1)) != 0) msb++;
      m = (msb >= 30) ? (x >> (msb - 30)) : (x << (30 - msb));
      lg = msb;
      for (int i = 0; i < FRAC; i++) begin
         m = (m * m) >> 30;
         lg = lg << 1;
         if (m >= (64'd2 << 30)) begin
            m = m >> 1;
            lg[0] = 1'b1;
         end
      end
      return (lg * LN2_WIDE + (64'd1 << 29)) >> 30;
   endfunction

   function automatic reading_type convert_sample(input logic [ADC_W-1:0] s);
      logic [63:0] fs, r25, beta, t0, v, r, num, q;
      longint lnr, den, celsius;
      reading_type res;
      fs = cfg_fs ? cfg_fs : 1;
      r25 = cfg_r25 ? cfg_r25 : 1;
      beta = cfg_beta ? cfg_beta : 1;
      t0 = cfg_t0 ? cfg_t0 : 1;
      if (s < OPEN_LIMIT) begin
         res.temp = OPEN_CENTI; res.code = ST_OPEN; return res;
      end
      v = (64'(s) * cfg_vref) / fs;
      if (v >= NEAR_SUPPLY_MV || v >= cfg_vref) r = 64'(cfg_pullup) * HIGH_R_FACTOR;
      else r = (v * cfg_pullup) / (64'(cfg_vref) - v);
      if (r == 0) begin
         res.temp = TEMP_MAX_CENTI; res.code = ST_SHORTED; return res;
      end
      lnr = longint'(ln_fixed(r)) - longint'(ln_fixed(r25));
      num = (64'(CENTI_SCALE) * beta) << FRAC;
      den = longint'(num) + lnr * longint'(t0);
      if (den == 0) begin
         res.temp = TEMP_MAX_CENTI; res.code = ST_CLAMP_HIGH; return res;
      end
      if (den < 0) begin
         res.temp = TEMP_MIN_CENTI; res.code = ST_CLAMP_LOW; return res;
      end
      num = num * t0;
      q = (num + 64'(den) / 2) / 64'(den);
      if (q > HOT_LIMIT_CENTIKELVIN) begin
         res.temp = TEMP_MAX_CENTI; res.code = ST_CLAMP_HIGH; return res;
      end
      celsius = longint'(q) - ZERO_C_CENTIKELVIN;
      if (celsius < -4000) begin
         res.temp = TEMP_MIN_CENTI; res.code = ST_CLAMP_LOW; return res;
      end
      res.temp = celsius[TEMP_BITS-1:0]; res.code = ST_NORMAL;
      return res;
   endfunction

   // driver: bursts of transfers with random gaps
   int burst_left = 0;
   int gap_left = 0;
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            expected_readings.push_back(convert_sample(req_adc_sample));
            void'(sample_queue.pop_front());
         end
         if (gap_left > 0 || hold_sender || sample_queue.size() == 0 ||
             (start && !busy && sample_queue.size() == 0)) begin
            if (gap_left > 0) gap_left--;
            start <= 1'b0;
         end else begin
            start <= 1'b1;
            req_adc_sample <= sample_queue[0];
            if (burst_left > 0) burst_left--;
            else begin
               burst_left = $urandom_range(0, 20);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end
         end
      end
   end

   // monitor: compare each strobed result with the oldest expectation
   always @(posedge clock) begin
      reading_type want;
      if (!reset && rsp_strobe) begin
         if (expected_readings.size() == 0) begin
            report("result with nothing expected");
         end else begin
            want = expected_readings.pop_front();
            if (rsp_temperature_centi !== want.temp)
               report($sformatf("temperature %0d, expected %0d",
                  rsp_temperature_centi, want.temp));
            if (rsp_status !== want.code)
               report($sformatf("status %0d, expected %0d", rsp_status, want.code));
         end
      end
   end

   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] idx, input int value);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= value[CSR_DATA_BITS-1:0];
      @(negedge clock);
      csr_write <= 1'b0;
      case (idx)
         CSR_ADC_FULL_SCALE: cfg_fs = value[FS_BITS-1:0];
         CSR_VREF_MILLIVOLTS: cfg_vref = value[VREF_BITS-1:0];
         CSR_PULLUP_OHMS: cfg_pullup = value[OHM_BITS-1:0];
         CSR_R25_OHMS: cfg_r25 = value[OHM_BITS-1:0];
         CSR_BETA_KELVIN: cfg_beta = value[BETA_BITS-1:0];
         CSR_REFERENCE_CENTIKELVIN: cfg_t0 = value[T0_BITS-1:0];
         default: ;
      endcase
   endtask

   // wait for the pipe to drain fully
   task automatic drain();
      while (sample_queue.size() != 0 || start || expected_readings.size() != 0)
         @(negedge clock);
      repeat (LATENCY + 10) @(negedge clock);
   endtask

   task automatic setup(input int fs, input int vref, input int pu, input int r25,
                        input int beta, input int t0);
      write_reg(CSR_ADC_FULL_SCALE, fs);
      write_reg(CSR_VREF_MILLIVOLTS, vref);
      write_reg(CSR_PULLUP_OHMS, pu);
      write_reg(CSR_R25_OHMS, r25);
      write_reg(CSR_BETA_KELVIN, beta);
      write_reg(CSR_REFERENCE_CENTIKELVIN, t0);
   endtask

   task automatic queue_random(input int n);
      for (int i = 0; i < n; i++)
         sample_queue.push_back($urandom_range(0, 3) == 0 ?
            ADC_W'($urandom_range(0, 40)) : ADC_W'($urandom));
   endtask

   initial begin
      cfg_fs = 16'd4095; cfg_vref = 13'd3300; cfg_pullup = 20'd10000;
      cfg_r25 = 20'd10000; cfg_beta = 14'd3950; cfg_t0 = 16'd29815;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      // directed: open limit, mid scale, near supply, full scale
      sample_queue = '{0, 1, 9, 10, 11, 100, 500, 1000, 2048, 3000, 3500, 4000, 4070,
                       4082, 4083, 4094, 4095, 12'h555, 12'haaa};
      drain();
      // register writes at the extremes, plus an unused index
      write_reg(CSR_UNUSED_INDEX, 12345);
      setup(1, 1000, 1, 1, 1000, 20000);
      sample_queue = '{0, 10, 4095, 2000};
      drain();
      setup(65535, 5000, 1000000, 1000000, 10000, 40000);
      sample_queue = '{10, 2000, 4095, 3333};
      drain();
      setup(0, 0, 0, 0, 0, 0);
      sample_queue = '{10, 2000, 4095};
      drain();
      setup(4095, 3300, 10000, 10000, 3950, 29815);
      // random phases with varying settings
      for (int ph = 0; ph < 5; ph++) begin
         queue_random(RANDOM_ITEMS / 5);
         if (ph == 2) begin
            while (sample_queue.size() > RANDOM_ITEMS / 10) @(negedge clock);
            hold_sender = 1'b1;
            while (expected_readings.size() != 0) @(negedge clock);
            hold_sender = 1'b0;
         end
         drain();
         setup($urandom_range(1, 65535), $urandom_range(1000, 5000),
               $urandom_range(1, 1000000), $urandom_range(1, 1000000),
               $urandom_range(1000, 10000), $urandom_range(20000, 40000));
         if (ph == 3) setup(4095, $urandom_range(1000, 5000), $urandom_range(1, 100000),
                            $urandom_range(1, 100000), $urandom_range(1000, 10000),
                            $urandom_range(20000, 40000));
      end
      queue_random(20);
      drain();
      if (mismatches == 0) $display("SCOREBOARD CLEAN");
      else $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      #2000000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule
`default_nettype wire

FILE: sim.f
hw/rtl/tad_pkg.sv
hw/rtl/tad_div_cell.sv
hw/rtl/tad_divider.sv
hw/rtl/tad_log.sv
hw/rtl/thermistor_adc_to_temperature.sv
tb/sv/tb_thermistor_adc_to_temperature.sv
